@@ rtl/core/pvd_pkg.sv @@
// ----------------------------------------------------------------------------
// pvd_pkg
// Types and constants shared by the prefix varint decoder modules.
// ----------------------------------------------------------------------------
package pvd_pkg;

    // bits taken from the selector byte of a two-byte and a four-byte varint
    localparam int unsigned SEL2_BITS = 6;
    localparam int unsigned SEL4_BITS = 5;
    // bit position of the third byte's contribution in a four-byte varint
    localparam int unsigned B2_SHIFT = 13;

    typedef enum logic [1:0] {
        PH_SEL     = 2'd0,
        PH_COLLECT = 2'd1,
        PH_DROP    = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_OVERRUN  = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } pvd_in_t;

    typedef struct packed {
        logic [15:0] value;
        status_t     status;
        logic        at_buffer_end;
    } pvd_out_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  bytes_remaining;
        logic [1:0]  byte_position;
        logic [15:0] partial_value;
        logic        excess_bits_seen;
    } pvd_state_t;

    localparam pvd_state_t STATE_CLEAR = '{
        phase:            PH_SEL,
        bytes_remaining:  2'd0,
        byte_position:    2'd0,
        partial_value:    16'd0,
        excess_bits_seen: 1'b0
    };

endpackage

@@ rtl/core/pvd_step.sv @@
// ----------------------------------------------------------------------------
// pvd_step
// Per-byte decode: next decoder state and the optional result for one beat.
// ----------------------------------------------------------------------------
module pvd_step (
    input  pvd_pkg::pvd_state_t state,
    input  pvd_pkg::pvd_in_t    in_beat,
    output pvd_pkg::pvd_state_t state_next,
    output logic                res_valid,
    output pvd_pkg::pvd_out_t   res
);

    logic [7:0]          b;
    logic                b_end;
    pvd_pkg::pvd_state_t acc;

    assign b     = in_beat.data_byte;
    assign b_end = in_beat.buffer_end;

    always_comb begin
        acc                 = state;
        state_next          = pvd_pkg::STATE_CLEAR;
        res_valid           = 1'b0;
        res.value           = 16'd0;
        res.status          = pvd_pkg::ST_OK;
        res.at_buffer_end   = b_end;

        unique case (state.phase)
            pvd_pkg::PH_DROP: begin
                state_next       = state;
                state_next.phase = b_end ? pvd_pkg::PH_SEL : pvd_pkg::PH_DROP;
            end

            pvd_pkg::PH_COLLECT: begin
                if (state.byte_position == 2'd1) begin
                    if (state.bytes_remaining == 2'd1) begin
                        acc.partial_value = state.partial_value
                            | {2'b00, b, 6'd0};
                    end else begin
                        acc.partial_value = state.partial_value
                            | {3'b000, b, 5'd0};
                    end
                end else if (state.byte_position == 2'd2) begin
                    acc.partial_value = state.partial_value
                        | {b[2:0], 13'd0};
                    if (b[7:3] != 5'd0) begin
                        acc.excess_bits_seen = 1'b1;
                    end
                end else begin
                    if (b != 8'd0) begin
                        acc.excess_bits_seen = 1'b1;
                    end
                end
                acc.bytes_remaining = state.bytes_remaining - 2'd1;
                acc.byte_position   = state.byte_position + 2'd1;

                if (acc.bytes_remaining == 2'd0) begin
                    res_valid = 1'b1;
                    if (acc.excess_bits_seen) begin
                        res.status       = pvd_pkg::ST_OVERFLOW;
                        state_next.phase = b_end ? pvd_pkg::PH_SEL : pvd_pkg::PH_DROP;
                    end else begin
                        res.value = acc.partial_value;
                    end
                end else if (b_end) begin
                    res_valid  = 1'b1;
                    res.status = pvd_pkg::ST_OVERRUN;
                end else begin
                    state_next = acc;
                end
            end

            default: begin
                // selector byte, also the unused phase code
                if (!b[0]) begin
                    res_valid = 1'b1;
                    res.value = {9'd0, b[7:1]};
                end else if (b[1] && b[2]) begin
                    // bigint selector
                    res_valid        = 1'b1;
                    res.status       = pvd_pkg::ST_OVERFLOW;
                    state_next.phase = b_end ? pvd_pkg::PH_SEL : pvd_pkg::PH_DROP;
                end else if (b_end) begin
                    res_valid  = 1'b1;
                    res.status = pvd_pkg::ST_OVERRUN;
                end else begin
                    state_next.phase         = pvd_pkg::PH_COLLECT;
                    state_next.byte_position = 2'd1;
                    if (!b[1]) begin
                        state_next.partial_value   = {10'd0, b[7:2]};
                        state_next.bytes_remaining = 2'd1;
                    end else begin
                        state_next.partial_value   = {11'd0, b[7:3]};
                        state_next.bytes_remaining = 2'd3;
                    end
                end
            end
        endcase
    end

endmodule

@@ rtl/core/prefix_varint_decoder.sv @@
// an accepted byte is held in the input register and decoded from there; its result is registered for m_valid
// throughput: one byte per cycle, sustained while m_ready stays high
// the input register and the result register stall together, so a waiting result
// holds back only the byte behind it
// reset: aresetn is synchronous, active low; both stages empty, decoder expects a selector
// ----------------------------------------------------------------------------
// prefix_varint_decoder
// Decodes prefix-coded unsigned varints from a byte stream into 16-bit values.
// ----------------------------------------------------------------------------
module prefix_varint_decoder (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pvd_pkg::pvd_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pvd_pkg::pvd_out_t  m_data
);

    logic                in_valid_reg, in_valid_next;
    pvd_pkg::pvd_in_t    in_data_reg, in_data_next;
    pvd_pkg::pvd_state_t state_reg, state_next;
    logic                m_valid_reg, m_valid_next;
    pvd_pkg::pvd_out_t   m_data_reg, m_data_next;

    pvd_pkg::pvd_state_t step_state;
    logic                step_res_valid;
    pvd_pkg::pvd_out_t   step_res;
    logic                out_free;
    logic                step_go;

    pvd_step u_step (
        .state      (state_reg),
        .in_beat    (in_data_reg),
        .state_next (step_state),
        .res_valid  (step_res_valid),
        .res        (step_res)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign step_go  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_data_next  = in_data_reg;
        state_next    = state_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_data_next  = s_data;
        end else if (step_go) begin
            in_valid_next = 1'b0;
        end

        if (step_go) begin
            state_next   = step_state;
            m_valid_next = step_res_valid;
            if (step_res_valid) begin
                m_data_next = step_res;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= pvd_pkg::STATE_CLEAR;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        in_data_reg <= in_data_next;
        m_data_reg  <= m_data_next;
    end

    // an overrun is only ever reported on the buffer's last beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_data_reg.status == pvd_pkg::ST_OVERRUN)
        |-> m_data_reg.at_buffer_end)
        else $error("overrun result without buffer end");

    // error results carry a zero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_data_reg.status != pvd_pkg::ST_OK)
        |-> (m_data_reg.value == 16'd0))
        else $error("error result with nonzero value");

    // the buffer's last beat always leaves the decoder expecting a selector
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_go && in_data_reg.buffer_end |=> (state_reg.phase == pvd_pkg::PH_SEL))
        else $error("decoder not back at selector after buffer end");

    // continuation count only lives while collecting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase != pvd_pkg::PH_COLLECT) |-> (state_reg.bytes_remaining == 2'd0))
        else $error("bytes remaining outside collect phase");

    // a held result is not overwritten while the sink stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !step_go)
        else $error("decode step advanced into a stalled result");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte buffers of prefix-coded varints into prefix_varint_decoder,
// predicts every decoded value, overflow and overrun in a local decoder model
// and checks each result beat against it, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned RANDOM_BEATS  = 1600;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned HOLD_AT       = 120;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam int unsigned DRAIN_CYCLES  = 8;

    typedef struct {
        pvd_pkg::pvd_in_t beat;
        int unsigned      gap;
    } send_item_t;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    pvd_pkg::pvd_in_t  s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    pvd_pkg::pvd_out_t m_data;

    prefix_varint_decoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    send_item_t        send_queue[$];
    pvd_pkg::pvd_out_t decoded_results[$];
    int unsigned       beats_total    = 0;
    int unsigned       beats_accepted = 0;
    int unsigned       fail_count     = 0;
    logic              send_burst     = 1'b0;

    // decoder model state
    pvd_pkg::phase_t dec_phase  = pvd_pkg::PH_SEL;
    logic [1:0]      dec_left   = '0;
    logic [1:0]      dec_pos    = '0;
    logic [15:0]     dec_value  = '0;
    logic            dec_excess = 1'b0;

    task automatic clear_varint();
        dec_left   = '0;
        dec_pos    = '0;
        dec_value  = '0;
        dec_excess = 1'b0;
    endtask

    // works out the result, if any, that one byte of the stream gives
    task automatic decode_byte(input pvd_pkg::pvd_in_t beat);
        logic [7:0]        b;
        logic              last;
        logic              emitted;
        pvd_pkg::pvd_out_t res;
        b       = beat.data_byte;
        last    = beat.buffer_end;
        emitted = 1'b0;
        res     = '{value: 16'd0, status: pvd_pkg::ST_OK, at_buffer_end: last};
        case (dec_phase)
            pvd_pkg::PH_DROP: begin
                if (last) dec_phase = pvd_pkg::PH_SEL;
            end
            pvd_pkg::PH_COLLECT: begin
                if (dec_pos == 2'd1) begin
                    if (dec_left == 2'd1)
                        dec_value = dec_value | (16'(b) << pvd_pkg::SEL2_BITS);
                    else
                        dec_value = dec_value | (16'(b) << pvd_pkg::SEL4_BITS);
                end else if (dec_pos == 2'd2) begin
                    dec_value = dec_value | (16'(b[2:0]) << pvd_pkg::B2_SHIFT);
                    if (b[7:3] != 5'd0) dec_excess = 1'b1;
                end else if (b != 8'd0) begin
                    dec_excess = 1'b1;
                end
                dec_left = dec_left - 2'd1;
                dec_pos  = dec_pos + 2'd1;
                if (dec_left == 2'd0) begin
                    emitted = 1'b1;
                    if (dec_excess) begin
                        res.status = pvd_pkg::ST_OVERFLOW;
                        dec_phase  = last ? pvd_pkg::PH_SEL : pvd_pkg::PH_DROP;
                    end else begin
                        res.value = dec_value;
                        dec_phase = pvd_pkg::PH_SEL;
                    end
                    clear_varint();
                end else if (last) begin
                    // buffer cut off mid-varint: overrun wins over pending overflow
                    emitted    = 1'b1;
                    res.status = pvd_pkg::ST_OVERRUN;
                    dec_phase  = pvd_pkg::PH_SEL;
                    clear_varint();
                end
            end
            default: begin
                dec_phase = pvd_pkg::PH_SEL;
                clear_varint();
                emitted = 1'b1;
                if (!b[0]) begin
                    res.value = 16'(b[7:1]);
                end else if (b[2:1] == 2'b11) begin
                    // bigint selector
                    res.status = pvd_pkg::ST_OVERFLOW;
                    dec_phase  = last ? pvd_pkg::PH_SEL : pvd_pkg::PH_DROP;
                end else begin
                    if (!b[1]) begin
                        dec_value = 16'(b[7:2]);
                        dec_left  = 2'd1;
                    end else begin
                        dec_value = 16'(b[7:3]);
                        dec_left  = 2'd3;
                    end
                    dec_pos = 2'd1;
                    if (last) begin
                        clear_varint();
                        res.status = pvd_pkg::ST_OVERRUN;
                    end else begin
                        emitted   = 1'b0;
                        dec_phase = pvd_pkg::PH_COLLECT;
                    end
                end
            end
        endcase
        if (emitted) decoded_results.push_back(res);
    endtask

    task automatic push_beat(input logic [7:0] b, input logic last);
        send_item_t item;
        item.beat = '{data_byte: b, buffer_end: last};
        item.gap  = send_burst ? 0 : $urandom_range(0, 14);
        send_queue.push_back(item);
        beats_total++;
    endtask

    task automatic note_failure(input string what, input pvd_pkg::pvd_out_t want,
                                input pvd_pkg::pvd_out_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch (%s): expected value %0d status %0d end %0d,",
                     what, want.value, want.status, want.at_buffer_end,
                     " got value %0d status %0d end %0d",
                     got.value, got.status, got.at_buffer_end);
    endtask

    // ---------------- driver ----------------
    int unsigned send_idle = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_idle = 0;
        end else if (!s_valid || s_ready) begin
            if (send_queue.size() != 0 && send_idle >= send_queue[0].gap) begin
                s_data  <= send_queue[0].beat;
                s_valid <= 1'b1;
                void'(send_queue.pop_front());
                send_idle = 0;
            end else begin
                s_valid <= 1'b0;
                if (send_queue.size() != 0) send_idle++;
            end
        end
    end

    // ---------------- receiver ready ----------------
    int unsigned recv_wait    = 0;
    int unsigned hold_left    = 0;
    int unsigned recv_count   = 0;
    logic        recv_burst   = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            recv_count++;
            if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
            recv_wait = recv_burst ? 0 : $urandom_range(0, 14);
            // one long hold-off so the decoder fills up and stalls its input
            if (recv_count == HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (recv_wait == 0);
            end
        end else if (recv_wait != 0) begin
            recv_wait--;
            m_ready <= (recv_wait == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ---------------- monitor ----------------
    pvd_pkg::pvd_out_t want;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                decode_byte(s_data);
                beats_accepted++;
            end
            if (m_valid && m_ready) begin
                if (decoded_results.size() == 0) begin
                    note_failure("unexpected beat", '0, m_data);
                end else begin
                    want = decoded_results.pop_front();
                    if (m_data.value !== want.value || m_data.status !== want.status
                        || m_data.at_buffer_end !== want.at_buffer_end)
                        note_failure("field", want, m_data);
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    int unsigned stall_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic random_buffer();
        logic [7:0]  bytes[$];
        int unsigned nvar;
        int unsigned kind;
        int unsigned k;
        nvar = $urandom_range(1, 5);
        for (int v = 0; v < nvar; v++) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                bytes.push_back({7'($urandom), 1'b0});
            end else if (kind < 65) begin
                bytes.push_back({6'($urandom), 2'b01});
                bytes.push_back(8'($urandom));
            end else if (kind < 88) begin
                bytes.push_back({5'($urandom), 3'b011});
                bytes.push_back(8'($urandom));
                bytes.push_back({5'd0, 3'($urandom)});
                bytes.push_back(8'd0);
            end else if (kind < 94) begin
                // four-byte varint that mostly carries bits beyond sixteen
                bytes.push_back({5'($urandom), 3'b011});
                bytes.push_back(8'($urandom));
                bytes.push_back(8'($urandom));
                bytes.push_back($urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(1, 255)));
            end else if (kind < 97) begin
                bytes.push_back({5'($urandom), 3'b111});
            end else begin
                bytes.push_back(8'($urandom));
            end
        end
        // now and then cut the buffer off mid-varint
        if ($urandom_range(0, 7) == 0) begin
            if ($urandom_range(0, 1) != 0) begin
                bytes.push_back({6'($urandom), 2'b01});
            end else begin
                bytes.push_back({5'($urandom), 3'b011});
                k = $urandom_range(0, 2);
                for (int i = 0; i < k; i++) bytes.push_back(8'($urandom));
            end
        end
        foreach (bytes[i]) push_beat(bytes[i], i == bytes.size() - 1);
    endtask

    initial begin
        // {buffer_end, data_byte}
        logic [8:0] directed[] = '{
            9'h000, 9'h1FE,
            9'h001, 9'h000,
            9'h0FD, 9'h1FF,
            9'h003, 9'h0FF, 9'h007, 9'h000,
            9'h003, 9'h000, 9'h008, 9'h000, 9'h155,
            9'h00B, 9'h000, 9'h000, 9'h180,
            9'h007, 9'h1AA,
            9'h1FF,
            9'h101,
            9'h003, 9'h000, 9'h1F8
        };
        int unsigned directed_beats;

        foreach (directed[i]) push_beat(directed[i][7:0], directed[i][8]);
        directed_beats = beats_total;
        while (beats_total - directed_beats < RANDOM_BEATS) begin
            if ($urandom_range(0, 7) == 0) send_burst = !send_burst;
            if ($urandom_range(0, 9) == 0) begin
                // stray bytes with random buffer ends
                repeat ($urandom_range(1, 6)) push_beat(8'($urandom), 1'($urandom));
            end else begin
                random_buffer();
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (beats_accepted != beats_total) @(posedge aclk);
        while (decoded_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && decoded_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/pvd_pkg.sv
rtl/core/pvd_step.sv
rtl/core/prefix_varint_decoder.sv
bench/testbench.sv
